// ===== design/cmv_pkg.sv =====
// ----------------------------------------------------------------------------
// cmv_pkg
// Shared widths, register indexes and arithmetic helpers for the complex
// matrix-vector multiplier.
// ----------------------------------------------------------------------------
package cmv_pkg;

    localparam int MAX_DIM    = 64;
    localparam int FRAC_BITS  = 14;
    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int CNT_W      = IDX_W + 1;
    localparam int CFG_W      = 7;
    localparam int VAL_W      = 16;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int ACC_W      = 40;
    localparam int CFG_ADDR_W = 2;

    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_ROW_COUNT    = cfg_addr_t'(0);
    localparam cfg_addr_t REG_COLUMN_COUNT = cfg_addr_t'(1);

    function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] c);
        logic [CNT_W-1:0] r;
        if (c == '0)
        begin
            r = CNT_W'(1);
        end
        else if (32'(c) > MAX_DIM)
        begin
            r = CNT_W'(MAX_DIM);
        end
        else
        begin
            r = CNT_W'(c);
        end
        return r;
    endfunction

    // Round half up from the accumulator scale to Q1.14, then saturate.
    function automatic logic [VAL_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0]           t;
        logic [ACC_W-FRAC_BITS:0]        q;
        logic [ACC_W-FRAC_BITS-VAL_W+1:0] top;
        logic [VAL_W-1:0]                r;
        t   = (ACC_W+1)'(acc) + (ACC_W+1)'(1 << (FRAC_BITS - 1));
        q   = t[ACC_W:FRAC_BITS];
        top = q[ACC_W-FRAC_BITS:VAL_W-1];
        if ((&top) || !(|top))
        begin
            r = q[VAL_W-1:0];
        end
        else if (q[ACC_W-FRAC_BITS])
        begin
            r = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(VAL_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== design/cmv_if.sv =====
// ----------------------------------------------------------------------------
// cmv_if
// Channel interfaces of the complex matrix-vector multiplier: element input,
// result output and configuration write.
// ----------------------------------------------------------------------------
interface cmv_in_if
    import cmv_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic signed [VAL_W-1:0] value_re;
    logic signed [VAL_W-1:0] value_im;

    modport source (output valid, func, value_re, value_im, input ready);
    modport sink   (input valid, func, value_re, value_im, output ready);
endinterface

interface cmv_out_if
    import cmv_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] out_re;
    logic signed [VAL_W-1:0] out_im;
    logic                    last_row;

    modport source (output valid, out_re, out_im, last_row, input ready);
    modport sink   (input valid, out_re, out_im, last_row, output ready);
endinterface

interface cmv_cfg_if
    import cmv_pkg::*;
;
    logic             valid;
    logic             ready;
    cfg_addr_t        index;
    logic [CFG_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/complex_matrix_vector_multiply.sv =====
// ----------------------------------------------------------------------------
// complex_matrix_vector_multiply
// Streams y = A * x over complex Q1.14 numbers with one multiply-accumulate
// per matrix element.
// ----------------------------------------------------------------------------
// A word with func 0 stores the next x element; a word with func 1 is the next
// matrix element in row-major order, and after the last column of each row one
// rounded, saturated y element comes out, flagged on the final row. One word is
// taken every cycle; a vector word is done at acceptance, and a matrix word
// passes a store-read stage, a product stage, an accumulate stage and a rounding
// stage on its way to its row's result. A held result stalls the input only once
// every stage in front of the output is full. Writing either count restarts the
// vector load and the product.
module complex_matrix_vector_multiply
    import cmv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    cmv_in_if.sink       elem,
    cmv_out_if.source    result,
    cmv_cfg_if.sink      cfg
);

    logic [CFG_W-1:0] row_count_reg;
    logic [CFG_W-1:0] column_count_reg;
    logic [CNT_W-1:0] rows_eff;
    logic [CNT_W-1:0] cols_eff;

    logic [IDX_W-1:0] load_idx_reg;
    logic [IDX_W-1:0] col_idx_reg;
    logic [IDX_W-1:0] row_idx_reg;
    logic             at_last_col;
    logic             at_last_row;
    logic             at_last_load;

    logic [2*VAL_W-1:0] vec_mem [MAX_DIM];

    logic                    s1_v_reg;
    logic                    s1_last_col_reg;
    logic                    s1_last_row_reg;
    logic signed [VAL_W-1:0] s1_re_reg;
    logic signed [VAL_W-1:0] s1_im_reg;
    logic [2*VAL_W-1:0]      s1_x_reg;
    logic signed [VAL_W-1:0] s1_xr;
    logic signed [VAL_W-1:0] s1_xi;

    logic                     s2_v_reg;
    logic                     s2_last_col_reg;
    logic                     s2_last_row_reg;
    logic signed [PROD_W-1:0] p_rr_reg;
    logic signed [PROD_W-1:0] p_ii_reg;
    logic signed [PROD_W-1:0] p_ri_reg;
    logic signed [PROD_W-1:0] p_ir_reg;

    logic signed [ACC_W-1:0] acc_re_reg;
    logic signed [ACC_W-1:0] acc_im_reg;
    logic signed [ACC_W-1:0] acc_re_next;
    logic signed [ACC_W-1:0] acc_im_next;

    logic                    s3_v_reg;
    logic                    s3_last_row_reg;
    logic signed [ACC_W-1:0] s3_re_reg;
    logic signed [ACC_W-1:0] s3_im_reg;

    logic                    out_v_reg;
    logic                    out_last_reg;
    logic [VAL_W-1:0]        out_re_reg;
    logic [VAL_W-1:0]        out_im_reg;

    logic out_free;
    logic s3_ok;
    logic s2_ok;
    logic s1_ok;
    logic s2_fire;
    logic in_fire;
    logic vec_fire;
    logic mat_fire;
    logic cfg_fire;

    assign rows_eff = eff_count(row_count_reg);
    assign cols_eff = eff_count(column_count_reg);

    assign at_last_col  = (CNT_W'(col_idx_reg) + CNT_W'(1)) == cols_eff;
    assign at_last_row  = (CNT_W'(row_idx_reg) + CNT_W'(1)) == rows_eff;
    assign at_last_load = (CNT_W'(load_idx_reg) + CNT_W'(1)) == cols_eff;

    // Stalls ripple back only through stages that actually hold a word.
    assign out_free = !out_v_reg || result.ready;
    assign s3_ok    = !s3_v_reg || out_free;
    assign s2_ok    = !s2_v_reg || !s2_last_col_reg || s3_ok;
    assign s1_ok    = !s1_v_reg || s2_ok;
    assign s2_fire  = s2_v_reg && s2_ok;

    assign elem.ready = s1_ok;
    assign in_fire    = elem.valid && s1_ok;
    assign vec_fire   = in_fire && !elem.func;
    assign mat_fire   = in_fire && elem.func;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid;

    assign result.valid    = out_v_reg;
    assign result.out_re   = out_re_reg;
    assign result.out_im   = out_im_reg;
    assign result.last_row = out_last_reg;

    assign s1_xr = s1_x_reg[2*VAL_W-1:VAL_W];
    assign s1_xi = s1_x_reg[VAL_W-1:0];

    always_comb
    begin
        acc_re_next = acc_re_reg + ACC_W'(p_rr_reg) - ACC_W'(p_ii_reg);
        acc_im_next = acc_im_reg + ACC_W'(p_ri_reg) + ACC_W'(p_ir_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= CFG_W'(MAX_DIM);
            column_count_reg <= CFG_W'(MAX_DIM);
            load_idx_reg     <= '0;
            col_idx_reg      <= '0;
            row_idx_reg      <= '0;
        end
        else if (cfg_fire)
        begin
            case (cfg.index)
                REG_ROW_COUNT:
                begin
                    row_count_reg <= cfg.data;
                    load_idx_reg  <= '0;
                    col_idx_reg   <= '0;
                    row_idx_reg   <= '0;
                end
                REG_COLUMN_COUNT:
                begin
                    column_count_reg <= cfg.data;
                    load_idx_reg     <= '0;
                    col_idx_reg      <= '0;
                    row_idx_reg      <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (vec_fire)
        begin
            load_idx_reg <= at_last_load ? '0 : load_idx_reg + IDX_W'(1);
        end
        else if (mat_fire)
        begin
            col_idx_reg <= at_last_col ? '0 : col_idx_reg + IDX_W'(1);
            if (at_last_col)
            begin
                row_idx_reg <= at_last_row ? '0 : row_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (vec_fire)
        begin
            vec_mem[load_idx_reg] <= {elem.value_re, elem.value_im};
        end
        if (mat_fire)
        begin
            s1_x_reg        <= vec_mem[col_idx_reg];
            s1_re_reg       <= elem.value_re;
            s1_im_reg       <= elem.value_im;
            s1_last_col_reg <= at_last_col;
            s1_last_row_reg <= at_last_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_ok)
            begin
                s1_v_reg <= mat_fire;
            end
            if (s2_ok)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (s3_ok)
            begin
                s3_v_reg <= s2_fire && s2_last_col_reg;
            end
            if (out_free)
            begin
                out_v_reg <= s3_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_v_reg && s2_ok)
        begin
            p_rr_reg        <= s1_re_reg * s1_xr;
            p_ii_reg        <= s1_im_reg * s1_xi;
            p_ri_reg        <= s1_re_reg * s1_xi;
            p_ir_reg        <= s1_im_reg * s1_xr;
            s2_last_col_reg <= s1_last_col_reg;
            s2_last_row_reg <= s1_last_row_reg;
        end
        if (s2_fire && s2_last_col_reg)
        begin
            s3_re_reg       <= acc_re_next;
            s3_im_reg       <= acc_im_next;
            s3_last_row_reg <= s2_last_row_reg;
        end
        if (s3_v_reg && out_free)
        begin
            out_re_reg   <= round_sat(s3_re_reg);
            out_im_reg   <= round_sat(s3_im_reg);
            out_last_reg <= s3_last_row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (cfg_fire && (cfg.index == REG_ROW_COUNT || cfg.index == REG_COLUMN_COUNT))
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (s2_fire)
        begin
            acc_re_reg <= s2_last_col_reg ? '0 : acc_re_next;
            acc_im_reg <= s2_last_col_reg ? '0 : acc_im_next;
        end
    end

    // Input may stall only when every stage down to the output is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        !elem.ready |-> (s1_v_reg && s2_v_reg && s2_last_col_reg && s3_v_reg
                         && out_v_reg && !result.ready))
    else $error("input stalled while the pipeline had room");

    // Closing a row starts the next one from a cleared accumulator.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_fire && s2_last_col_reg) |=> (acc_re_reg == '0 && acc_im_reg == '0))
    else $error("accumulator not cleared after the last column of a row");

    // A row result cannot be overwritten before the output stage takes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s3_v_reg && !out_free) |=> (s3_v_reg && $stable(s3_re_reg) && $stable(s3_im_reg)))
    else $error("pending row result lost while the output was blocked");

endmodule

// ===== test/complex_matrix_vector_multiply_tb.sv =====
// ----------------------------------------------------------------------------
// complex_matrix_vector_multiply_tb
// Drives x-vector loads, matrix element streams and count writes into the
// complex matrix-vector multiplier with random gaps and result stalls. A
// fixed-point model kept in step with each accepted word predicts every y
// element, and each result word is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module complex_matrix_vector_multiply_tb;
    import cmv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic {FUNC_LOAD = 1'b0, FUNC_MATRIX = 1'b1} func_t;

    typedef struct {
        logic signed [VAL_W-1:0] re;
        logic signed [VAL_W-1:0] im;
        logic                    last_row;
    } y_elem_t;

    localparam cfg_addr_t REG_SPARE_2 = cfg_addr_t'(2);
    localparam cfg_addr_t REG_SPARE_3 = cfg_addr_t'(3);

    localparam logic signed [VAL_W-1:0] Q_MIN = 16'sh8000;
    localparam logic signed [VAL_W-1:0] Q_MAX = 16'sh7fff;

    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_WORDS  = 1450;
    localparam int PRINT_LIMIT   = 100;

    logic clk;
    logic rst_n;

    cmv_in_if  elem_ch ();
    cmv_out_if y_ch ();
    cmv_cfg_if cfg_ch ();

    complex_matrix_vector_multiply u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .elem   (elem_ch),
        .result (y_ch),
        .cfg    (cfg_ch)
    );

    logic [CFG_W-1:0]        row_reg    = CFG_W'(64);
    logic [CFG_W-1:0]        column_reg = CFG_W'(64);
    logic signed [VAL_W-1:0] x_re [MAX_DIM];
    logic signed [VAL_W-1:0] x_im [MAX_DIM];
    bit                      x_written [MAX_DIM];
    int                      load_idx = 0;
    int                      col_idx  = 0;
    int                      row_idx  = 0;
    logic signed [ACC_W-1:0] acc_re   = '0;
    logic signed [ACC_W-1:0] acc_im   = '0;

    y_elem_t y_expected [$];
    int      error_count = 0;
    int      word_count  = 0;
    bit      sender_busy   = 1'b0;
    bit      receiver_busy = 1'b0;
    int      stall_left    = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int dim_of(input logic [CFG_W-1:0] c);
        if (c == '0)
        begin
            return 1;
        end
        if (c > MAX_DIM)
        begin
            return MAX_DIM;
        end
        return int'(c);
    endfunction

    function automatic logic signed [VAL_W-1:0] to_q14(input logic signed [ACC_W-1:0] a);
        longint q;
        q = (longint'(a) + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (q > longint'(Q_MAX))
        begin
            q = longint'(Q_MAX);
        end
        if (q < longint'(Q_MIN))
        begin
            q = longint'(Q_MIN);
        end
        return VAL_W'(q);
    endfunction

    function automatic int pick_gap(input bit busy);
        int r;
        if (!busy)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_part(input bit full);
        int r;
        r = $urandom_range(0, 9);
        if (full)
        begin
            if (r == 0)
            begin
                return Q_MIN;
            end
            if (r == 1)
            begin
                return Q_MAX;
            end
            return VAL_W'($urandom);
        end
        return VAL_W'($urandom_range(0, 8191) - 4096);
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_LIMIT)
        begin
            $display("mismatch at %0t ns: %s", $time, what);
        end
    endtask

    task automatic advance_product(input func_t f, input logic signed [VAL_W-1:0] re,
                                   input logic signed [VAL_W-1:0] im);
        int      cols;
        int      rows;
        y_elem_t y;
        cols = dim_of(column_reg);
        rows = dim_of(row_reg);
        if (f == FUNC_LOAD)
        begin
            if (load_idx >= cols)
            begin
                load_idx = 0;
            end
            x_re[load_idx]      = re;
            x_im[load_idx]      = im;
            x_written[load_idx] = 1'b1;
            load_idx++;
            if (load_idx >= cols)
            begin
                load_idx = 0;
            end
        end
        else
        begin
            if (col_idx >= cols)
            begin
                col_idx = 0;
            end
            if (row_idx >= rows)
            begin
                row_idx = 0;
            end
            acc_re = ACC_W'(longint'(acc_re) + longint'(re) * longint'(x_re[col_idx])
                            - longint'(im) * longint'(x_im[col_idx]));
            acc_im = ACC_W'(longint'(acc_im) + longint'(re) * longint'(x_im[col_idx])
                            + longint'(im) * longint'(x_re[col_idx]));
            col_idx++;
            if (col_idx >= cols)
            begin
                col_idx    = 0;
                y.re       = to_q14(acc_re);
                y.im       = to_q14(acc_im);
                y.last_row = (row_idx + 1 >= rows);
                y_expected.push_back(y);
                acc_re = '0;
                acc_im = '0;
                row_idx++;
                if (row_idx >= rows)
                begin
                    row_idx = 0;
                end
            end
        end
    endtask

    task automatic send_word(input func_t f, input logic signed [VAL_W-1:0] re,
                             input logic signed [VAL_W-1:0] im);
        int gap;
        gap = pick_gap(sender_busy);
        repeat (gap)
        begin
            @(negedge clk);
            elem_ch.valid <= 1'b0;
        end
        @(negedge clk);
        elem_ch.valid    <= 1'b1;
        elem_ch.func     <= f;
        elem_ch.value_re <= re;
        elem_ch.value_im <= im;
        do
        begin
            @(posedge clk);
        end
        while (!elem_ch.ready);
        word_count++;
        advance_product(f, re, im);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        elem_ch.valid <= 1'b0;
        while (y_expected.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input cfg_addr_t index, input logic [CFG_W-1:0] data);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        if (index == REG_ROW_COUNT || index == REG_COLUMN_COUNT)
        begin
            if (index == REG_ROW_COUNT)
            begin
                row_reg = data;
            end
            else
            begin
                column_reg = data;
            end
            load_idx = 0;
            col_idx  = 0;
            row_idx  = 0;
            acc_re   = '0;
            acc_im   = '0;
        end
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic load_vector(input bit full);
        repeat (dim_of(column_reg))
        begin
            send_word(FUNC_LOAD, pick_part(full), pick_part(full));
        end
    endtask

    task automatic stream_matrix(input int n, input bit full);
        repeat (n)
        begin
            send_word(FUNC_MATRIX, pick_part(full), pick_part(full));
        end
    endtask

    // Reset counts are 64 by 64, so one full row yields a single non-final result.
    task automatic test_reset_counts();
        sender_busy   = 1'b1;
        receiver_busy = 1'b1;
        load_vector(1'b1);
        stream_matrix(64, 1'b1);
    endtask

    task automatic test_directed_cases();
        sender_busy   = 1'b0;
        receiver_busy = 1'b0;
        write_reg(REG_ROW_COUNT, CFG_W'(2));
        write_reg(REG_COLUMN_COUNT, CFG_W'(2));
        send_word(FUNC_LOAD, 16'sd16384, 16'sd0);
        send_word(FUNC_LOAD, Q_MIN, Q_MAX);
        send_word(FUNC_MATRIX, Q_MAX, Q_MAX);
        send_word(FUNC_MATRIX, Q_MIN, Q_MIN);
        wait_drained();
        send_word(FUNC_MATRIX, 16'sd1, 16'sd0);
        send_word(FUNC_LOAD, -16'sd1, -16'sd1);
        send_word(FUNC_MATRIX, 16'sd0, -16'sd1);
        send_word(FUNC_MATRIX, Q_MIN, 16'sd0);
        send_word(FUNC_MATRIX, 16'sd0, Q_MIN);
        send_word(FUNC_MATRIX, Q_MAX, 16'sd0);
        write_reg(REG_SPARE_2, CFG_W'(7'h55));
        write_reg(REG_SPARE_3, CFG_W'(7'h2a));
        send_word(FUNC_MATRIX, 16'sd0, 16'sd0);
        write_reg(REG_ROW_COUNT, CFG_W'(0));
        write_reg(REG_COLUMN_COUNT, CFG_W'(0));
        send_word(FUNC_MATRIX, Q_MAX, Q_MIN);
        send_word(FUNC_MATRIX, Q_MIN, Q_MAX);
    endtask

    task automatic test_count_limits();
        sender_busy   = 1'b1;
        receiver_busy = 1'b1;
        write_reg(REG_ROW_COUNT, CFG_W'(1));
        write_reg(REG_COLUMN_COUNT, CFG_W'(127));
        stream_matrix(64, 1'b0);
        write_reg(REG_ROW_COUNT, CFG_W'(127));
        write_reg(REG_COLUMN_COUNT, CFG_W'(1));
        stream_matrix(64, 1'b1);
        write_reg(REG_ROW_COUNT, CFG_W'(64));
        write_reg(REG_COLUMN_COUNT, CFG_W'(65));
        stream_matrix(64, 1'b1);
    endtask

    task automatic test_random_products();
        int               stop_words;
        int               kind;
        int               products;
        int               cells;
        int               stop_at;
        bit               full;
        func_t            f;
        logic [CFG_W-1:0] row_val;
        logic [CFG_W-1:0] col_val;
        stop_words = word_count + RANDOM_WORDS;
        while (word_count < stop_words)
        begin
            kind = $urandom_range(0, 19);
            if (kind == 0)
            begin
                row_val = CFG_W'($urandom_range(64, 127));
                col_val = CFG_W'($urandom_range(0, 2));
            end
            else if (kind == 1)
            begin
                row_val = CFG_W'($urandom_range(0, 2));
                col_val = CFG_W'($urandom_range(64, 127));
            end
            else if (kind == 2)
            begin
                row_val = CFG_W'($urandom_range(0, 127));
                col_val = CFG_W'($urandom_range(0, 1));
            end
            else if (kind == 3)
            begin
                row_val = CFG_W'($urandom_range(0, 1));
                col_val = CFG_W'($urandom_range(0, 127));
            end
            else
            begin
                row_val = CFG_W'($urandom_range(1, 8));
                col_val = CFG_W'($urandom_range(1, 8));
            end
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(REG_ROW_COUNT, row_val);
                write_reg(REG_COLUMN_COUNT, col_val);
            end
            else
            begin
                write_reg(REG_COLUMN_COUNT, col_val);
                write_reg(REG_ROW_COUNT, row_val);
            end
            if ($urandom_range(0, 7) == 0)
            begin
                write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3,
                          CFG_W'($urandom_range(0, 127)));
            end
            sender_busy   = ($urandom_range(0, 3) != 0);
            receiver_busy = ($urandom_range(0, 3) != 0);
            cells = dim_of(row_val) * dim_of(col_val);
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(10, 40))
                begin
                    f = func_t'($urandom_range(0, 1));
                    if (f == FUNC_MATRIX
                        && !x_written[(col_idx >= dim_of(column_reg)) ? 0 : col_idx])
                    begin
                        f = FUNC_LOAD;
                    end
                    send_word(f, pick_part(1'b1), pick_part(1'b1));
                end
            end
            else
            begin
                products = $urandom_range(1, 3);
                for (int p = 0; p < products; p++)
                begin
                    full = ($urandom_range(0, 2) == 0);
                    if (p == 0 || $urandom_range(0, 1) == 0)
                    begin
                        load_vector(full);
                    end
                    stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cells - 1) : cells;
                    for (int i = 0; i < stop_at; i++)
                    begin
                        if ($urandom_range(0, 39) == 0)
                        begin
                            send_word(FUNC_LOAD, pick_part(full), pick_part(full));
                        end
                        if ($urandom_range(0, 299) == 0)
                        begin
                            wait_drained();
                        end
                        send_word(FUNC_MATRIX, pick_part(full), pick_part(full));
                    end
                end
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            y_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            y_ch.ready <= 1'b1;
            stall_left <= pick_gap(receiver_busy);
        end
    end

    always @(posedge clk)
    begin : check_results
        y_elem_t want;
        if (rst_n && y_ch.valid && y_ch.ready)
        begin
            if (y_expected.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result re=%0d im=%0d last_row=%0b",
                                          y_ch.out_re, y_ch.out_im, y_ch.last_row));
            end
            else
            begin
                want = y_expected.pop_front();
                if (y_ch.out_re !== want.re)
                begin
                    report_mismatch($sformatf("out_re got %0d want %0d",
                                              y_ch.out_re, want.re));
                end
                if (y_ch.out_im !== want.im)
                begin
                    report_mismatch($sformatf("out_im got %0d want %0d",
                                              y_ch.out_im, want.im));
                end
                if (y_ch.last_row !== want.last_row)
                begin
                    report_mismatch($sformatf("last_row got %0b want %0b",
                                              y_ch.last_row, want.last_row));
                end
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        elem_ch.valid    = 1'b0;
        elem_ch.func     = FUNC_LOAD;
        elem_ch.value_re = '0;
        elem_ch.value_im = '0;
        y_ch.ready       = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_ROW_COUNT;
        cfg_ch.data      = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_counts();
        test_directed_cases();
        test_count_limits();
        test_random_products();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
